[rtl/heightfield_bilinear_sample_top_defines.svh]
// Assertion macros used by the height grid sampler checker.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLE_TOP_DEFINES_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/hbs_pkg.sv]
// Shared types and constants of the height grid sampler.
`default_nettype none

package hbs_pkg;

    localparam int NUM_STAGES = 10;

    // Pipeline stage positions
    localparam int ST_IN     = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_CLAMP  = 2;
    localparam int ST_READ   = 3;
    localparam int ST_DIFF   = 4;
    localparam int ST_WEIGHT = 5;
    localparam int ST_ROW    = 6;
    localparam int ST_RDIFF  = 7;
    localparam int ST_RMUL   = 8;
    localparam int ST_OUT    = 9;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        REG_GRID_VALID  = 3'd0,
        REG_X_ORIGIN    = 3'd1,
        REG_Y_ORIGIN    = 3'd2,
        REG_X_SCALE     = 3'd3,
        REG_Y_SCALE     = 3'd4,
        REG_LAST_COLUMN = 3'd5,
        REG_LAST_ROW    = 3'd6
    } reg_index_t;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
        logic                  mem_wr;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[rtl/hbs_axis.sv]
// Maps one query coordinate to a clamped grid index and 16-bit fraction.
`default_nettype none

module hbs_axis (
    input  logic                clk,
    input  hbs_pkg::pipe_ctrl_t ctrl,
    input  logic signed [31:0]  coord,
    input  logic signed [31:0]  origin,
    input  logic [31:0]         scale,
    input  logic [7:0]          last_index,
    output logic [7:0]          index,
    output logic [15:0]         frac
);

    logic signed [32:0] diff;
    logic [31:0]        dist_next;
    logic [31:0]        dist_reg;
    logic [63:0]        prod_full;
    logic [47:0]        pos_next;
    logic [47:0]        pos_reg;
    logic [47:0]        pos_lim;
    logic [47:0]        pos_clamped;
    logic [7:0]         index_reg;
    logic [15:0]        frac_reg;

    always_comb
    begin
        diff        = 33'(coord) - 33'(origin);
        dist_next   = (!diff[32] && (diff != '0)) ? diff[31:0] : '0;
        prod_full   = 64'(dist_reg) * 64'(scale);
        pos_next    = prod_full[63:16];
        pos_lim     = 48'({last_index, 16'h0000});
        pos_clamped = (pos_reg > pos_lim) ? pos_lim : pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[hbs_pkg::ST_IN])
        begin
            dist_reg <= dist_next;
        end
        if (ctrl.adv[hbs_pkg::ST_MUL])
        begin
            pos_reg <= pos_next;
        end
        if (ctrl.adv[hbs_pkg::ST_CLAMP])
        begin
            index_reg <= pos_clamped[23:16];
            frac_reg  <= pos_clamped[15:0];
        end
    end

    assign index = index_reg;
    assign frac  = frac_reg;

endmodule

`default_nettype wire

[rtl/hbs_grid.sv]
// Height grid in four row/column parity banks: sample writes and four-corner reads.
`default_nettype none

module hbs_grid #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  hbs_pkg::pipe_ctrl_t           ctrl,
    input  logic [7:0]                    load_column,
    input  logic [7:0]                    load_row,
    input  logic signed [15:0]            load_height,
    input  logic [7:0]                    col,
    input  logic [15:0]                   col_frac,
    input  logic [7:0]                    row,
    input  logic [15:0]                   row_frac,
    output logic signed [HEIGHT_BITS-1:0] ll,
    output logic signed [HEIGHT_BITS-1:0] lr,
    output logic signed [HEIGHT_BITS-1:0] ul,
    output logic signed [HEIGHT_BITS-1:0] ur
);

    localparam int USE_COLS   = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
    localparam int USE_ROWS   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
    localparam int BANK_COLS  = (USE_COLS + 1) / 2;
    localparam int BANK_ROWS  = (USE_ROWS + 1) / 2;
    localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int WST        = hbs_pkg::ST_CLAMP + 1;

    function automatic logic [BAW-1:0] bank_addr(input logic [7:0] r, input logic [7:0] c);
        return BAW'(32'(r[7:1]) * BANK_COLS + 32'(c[7:1]));
    endfunction

    logic [7:0]             wcol_reg [WST];
    logic [7:0]             wrow_reg [WST];
    logic [HEIGHT_BITS-1:0] wh_reg   [WST];
    logic                   wr_en;
    logic [BAW-1:0]         wr_addr;
    logic [7:0]             col1;
    logic [7:0]             row1;
    logic                   c0p_reg;
    logic                   c1p_reg;
    logic                   r0p_reg;
    logic                   r1p_reg;
    logic [HEIGHT_BITS-1:0] rd_q_reg [4];

    // Write path travels with the item so loads and queries stay in order
    always_ff @(posedge clk)
    begin
        if (ctrl.adv[hbs_pkg::ST_IN])
        begin
            wcol_reg[hbs_pkg::ST_IN] <= load_column;
            wrow_reg[hbs_pkg::ST_IN] <= load_row;
            wh_reg[hbs_pkg::ST_IN]   <= HEIGHT_BITS'(32'(load_height));
        end
        if (ctrl.adv[hbs_pkg::ST_MUL])
        begin
            wcol_reg[hbs_pkg::ST_MUL] <= wcol_reg[hbs_pkg::ST_IN];
            wrow_reg[hbs_pkg::ST_MUL] <= wrow_reg[hbs_pkg::ST_IN];
            wh_reg[hbs_pkg::ST_MUL]   <= wh_reg[hbs_pkg::ST_IN];
        end
        if (ctrl.adv[hbs_pkg::ST_CLAMP])
        begin
            wcol_reg[hbs_pkg::ST_CLAMP] <= wcol_reg[hbs_pkg::ST_MUL];
            wrow_reg[hbs_pkg::ST_CLAMP] <= wrow_reg[hbs_pkg::ST_MUL];
            wh_reg[hbs_pkg::ST_CLAMP]   <= wh_reg[hbs_pkg::ST_MUL];
        end
    end

    always_comb
    begin
        wr_en   = ctrl.mem_wr
                  && ({1'b0, wcol_reg[hbs_pkg::ST_CLAMP]} < 9'(USE_COLS))
                  && ({1'b0, wrow_reg[hbs_pkg::ST_CLAMP]} < 9'(USE_ROWS));
        wr_addr = bank_addr(wrow_reg[hbs_pkg::ST_CLAMP], wcol_reg[hbs_pkg::ST_CLAMP]);
        col1    = (col_frac != '0) ? col + 8'd1 : col;
        row1    = (row_frac != '0) ? row + 8'd1 : row;
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        localparam logic ROW_PAR = 1'((g >> 1) & 1);
        localparam logic COL_PAR = 1'(g & 1);

        logic [HEIGHT_BITS-1:0] mem [BANK_DEPTH];
        logic [7:0]             rd_row;
        logic [7:0]             rd_col;
        logic [BAW-1:0]         rd_addr;

        // Bank of the other parity gets the neighbor; unused when fraction is zero
        always_comb
        begin
            rd_row  = (row[0] == ROW_PAR) ? row : row1;
            rd_col  = (col[0] == COL_PAR) ? col : col1;
            rd_addr = bank_addr(rd_row, rd_col);
        end

        always_ff @(posedge clk)
        begin
            if (wr_en && (wrow_reg[hbs_pkg::ST_CLAMP][0] == ROW_PAR)
                      && (wcol_reg[hbs_pkg::ST_CLAMP][0] == COL_PAR))
            begin
                mem[wr_addr] <= wh_reg[hbs_pkg::ST_CLAMP];
            end
            if (ctrl.adv[hbs_pkg::ST_READ])
            begin
                rd_q_reg[g] <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[hbs_pkg::ST_READ])
        begin
            c0p_reg <= col[0];
            c1p_reg <= col1[0];
            r0p_reg <= row[0];
            r1p_reg <= row1[0];
        end
    end

    assign ll = signed'(rd_q_reg[{r0p_reg, c0p_reg}]);
    assign lr = signed'(rd_q_reg[{r0p_reg, c1p_reg}]);
    assign ul = signed'(rd_q_reg[{r1p_reg, c0p_reg}]);
    assign ur = signed'(rd_q_reg[{r1p_reg, c1p_reg}]);

endmodule

`default_nettype wire

[rtl/hbs_blend.sv]
// Bilinear blend pipeline: column pass, row pass, rounding and saturation.
`default_nettype none

module hbs_blend #(
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  hbs_pkg::pipe_ctrl_t           ctrl,
    input  logic                          grid_valid,
    input  logic [15:0]                   col_frac,
    input  logic [15:0]                   row_frac,
    input  logic signed [HEIGHT_BITS-1:0] ll,
    input  logic signed [HEIGHT_BITS-1:0] lr,
    input  logic signed [HEIGHT_BITS-1:0] ul,
    input  logic signed [HEIGHT_BITS-1:0] ur,
    output logic signed [31:0]            height_out,
    output logic                          found
);

    localparam int HB = HEIGHT_BITS;
    localparam int DW = HB + 1;
    localparam int PW = DW + 17;
    localparam int AW = HB + 2;
    localparam int EW = AW + 1;
    localparam int MW = EW + 17;
    localparam int VW = AW + 2;

    logic [15:0]           fx3_reg;
    logic [15:0]           fy3_reg;
    logic signed [HB-1:0]  ll4_reg;
    logic signed [HB-1:0]  ul4_reg;
    logic signed [DW-1:0]  dlo_reg;
    logic signed [DW-1:0]  dhi_reg;
    logic [15:0]           fx4_reg;
    logic [15:0]           fy4_reg;
    logic signed [HB-1:0]  ll5_reg;
    logic signed [HB-1:0]  ul5_reg;
    logic signed [PW-1:0]  plo_reg;
    logic signed [PW-1:0]  phi_reg;
    logic [15:0]           fy5_reg;
    logic signed [AW-1:0]  a6_reg;
    logic signed [AW-1:0]  b6_reg;
    logic [15:0]           fy6_reg;
    logic signed [AW-1:0]  a7_reg;
    logic signed [EW-1:0]  dab_reg;
    logic [15:0]           fy7_reg;
    logic signed [AW-1:0]  a8_reg;
    logic signed [MW-1:0]  m_reg;
    logic signed [VW-1:0]  v;
    logic signed [63:0]    vx;
    logic signed [31:0]    sat;
    logic signed [31:0]    height_reg;
    logic                  found_reg;

    always_comb
    begin
        v   = VW'(a8_reg) + VW'((m_reg + MW'(32768)) >>> 16);
        vx  = 64'(v);
        if (vx > hbs_pkg::SAT_MAX)
        begin
            sat = 32'(hbs_pkg::SAT_MAX);
        end
        else if (vx < hbs_pkg::SAT_MIN)
        begin
            sat = 32'(hbs_pkg::SAT_MIN);
        end
        else
        begin
            sat = 32'(vx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv[hbs_pkg::ST_READ])
        begin
            fx3_reg <= col_frac;
            fy3_reg <= row_frac;
        end
        if (ctrl.adv[hbs_pkg::ST_DIFF])
        begin
            ll4_reg <= ll;
            ul4_reg <= ul;
            dlo_reg <= DW'(lr) - DW'(ll);
            dhi_reg <= DW'(ur) - DW'(ul);
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
        end
        if (ctrl.adv[hbs_pkg::ST_WEIGHT])
        begin
            ll5_reg <= ll4_reg;
            ul5_reg <= ul4_reg;
            plo_reg <= PW'(dlo_reg) * PW'(signed'({1'b0, fx4_reg}));
            phi_reg <= PW'(dhi_reg) * PW'(signed'({1'b0, fx4_reg}));
            fy5_reg <= fy4_reg;
        end
        // floor(lo / 2^16) == ll + floor(dlo * fx / 2^16)
        if (ctrl.adv[hbs_pkg::ST_ROW])
        begin
            a6_reg  <= AW'(ll5_reg) + AW'(plo_reg >>> 16);
            b6_reg  <= AW'(ul5_reg) + AW'(phi_reg >>> 16);
            fy6_reg <= fy5_reg;
        end
        if (ctrl.adv[hbs_pkg::ST_RDIFF])
        begin
            a7_reg  <= a6_reg;
            dab_reg <= EW'(b6_reg) - EW'(a6_reg);
            fy7_reg <= fy6_reg;
        end
        if (ctrl.adv[hbs_pkg::ST_RMUL])
        begin
            a8_reg <= a7_reg;
            m_reg  <= MW'(dab_reg) * MW'(signed'({1'b0, fy7_reg}));
        end
        if (ctrl.adv[hbs_pkg::ST_OUT])
        begin
            height_reg <= grid_valid ? sat : '0;
            found_reg  <= grid_valid;
        end
    end

    assign height_out = height_reg;
    assign found      = found_reg;

endmodule

`default_nettype wire

[rtl/heightfield_bilinear_sample_top.sv]
// Top level of the bilinear height grid sampler.
//
// Input channel (in_valid/in_ready) carries load and query items; op selects.
// A load writes one grid sample and yields no result. A query yields exactly
// one result on the output channel (out_valid/out_ready): the bilinear blend
// of the four neighboring samples, or found = 0 and height 0 while the grid
// is marked invalid. Registers are written over cfg_valid/cfg_ready/cfg_index/
// cfg_data; the user must write them only while no item is in flight, and
// the block itself does not enforce this. cfg_ready is always high. One item
// can enter every cycle while in_ready is high. Items pass through ten register
// stages: input capture, coordinate multiply, clamp, bank read (four parity
// banks), corner difference, column weight, column sum, row difference, row
// multiply and the output register; the transfer edge itself loads the first
// of them. Reset empties the pipeline and loads register defaults; grid
// contents are undefined until written. When the receiver stalls, the output
// holds and stages behind it keep filling bubbles; in_ready drops only when
// every stage is occupied.
`default_nettype none

module heightfield_bilinear_sample_top #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [7:0]         load_column,
    input  logic [7:0]         load_row,
    input  logic signed [15:0] load_height,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] height_out,
    output logic               found,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int NS = hbs_pkg::NUM_STAGES;

    logic                          grid_valid_reg;
    logic signed [31:0]            x_origin_reg;
    logic signed [31:0]            y_origin_reg;
    logic [31:0]                   x_scale_reg;
    logic [31:0]                   y_scale_reg;
    logic [7:0]                    last_column_reg;
    logic [7:0]                    last_row_reg;
    logic [7:0]                    last_col_use;
    logic [7:0]                    last_row_use;
    logic [NS-1:0]                 vld_reg;
    logic [NS-1:0]                 vld_next;
    logic [NS-1:0]                 adv;
    logic [hbs_pkg::ST_CLAMP:0]    op_reg;
    hbs_pkg::pipe_ctrl_t           ctrl;
    logic [7:0]                    col_idx;
    logic [15:0]                   col_frac;
    logic [7:0]                    row_idx;
    logic [15:0]                   row_frac;
    logic signed [HEIGHT_BITS-1:0] h_ll;
    logic signed [HEIGHT_BITS-1:0] h_lr;
    logic signed [HEIGHT_BITS-1:0] h_ul;
    logic signed [HEIGHT_BITS-1:0] h_ur;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_valid_reg  <= 1'b0;
            x_origin_reg    <= '0;
            y_origin_reg    <= '0;
            x_scale_reg     <= 32'd65536;
            y_scale_reg     <= 32'd65536;
            last_column_reg <= 8'd255;
            last_row_reg    <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (hbs_pkg::reg_index_t'(cfg_index))
                hbs_pkg::REG_GRID_VALID:  grid_valid_reg  <= cfg_data[0];
                hbs_pkg::REG_X_ORIGIN:    x_origin_reg    <= signed'(cfg_data);
                hbs_pkg::REG_Y_ORIGIN:    y_origin_reg    <= signed'(cfg_data);
                hbs_pkg::REG_X_SCALE:     x_scale_reg     <= cfg_data;
                hbs_pkg::REG_Y_SCALE:     y_scale_reg     <= cfg_data;
                hbs_pkg::REG_LAST_COLUMN: last_column_reg <= cfg_data[7:0];
                hbs_pkg::REG_LAST_ROW:    last_row_reg    <= cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        last_col_use = (32'(last_column_reg) > MAX_COLUMNS - 1) ? 8'(MAX_COLUMNS - 1)
                                                               : last_column_reg;
        last_row_use = (32'(last_row_reg) > MAX_ROWS - 1) ? 8'(MAX_ROWS - 1)
                                                         : last_row_reg;
    end

    // Stage k loads when it is empty or its item moves on
    always_comb
    begin
        adv[hbs_pkg::ST_OUT] = !vld_reg[hbs_pkg::ST_OUT] || out_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
        vld_next[0] = in_valid;
        for (int k = 1; k < NS; k++)
        begin
            vld_next[k] = vld_reg[k - 1];
        end
        // loads leave the pipeline once written
        vld_next[hbs_pkg::ST_READ] = vld_reg[hbs_pkg::ST_CLAMP]
                                     && (op_reg[hbs_pkg::ST_CLAMP] == hbs_pkg::OP_QUERY);
        ctrl.adv    = adv;
        ctrl.mem_wr = adv[hbs_pkg::ST_READ] && vld_reg[hbs_pkg::ST_CLAMP]
                      && (op_reg[hbs_pkg::ST_CLAMP] == hbs_pkg::OP_LOAD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_next & adv) | (vld_reg & ~adv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[hbs_pkg::ST_IN])
        begin
            op_reg[hbs_pkg::ST_IN] <= op;
        end
        if (adv[hbs_pkg::ST_MUL])
        begin
            op_reg[hbs_pkg::ST_MUL] <= op_reg[hbs_pkg::ST_IN];
        end
        if (adv[hbs_pkg::ST_CLAMP])
        begin
            op_reg[hbs_pkg::ST_CLAMP] <= op_reg[hbs_pkg::ST_MUL];
        end
    end

    assign in_ready  = adv[hbs_pkg::ST_IN];
    assign out_valid = vld_reg[hbs_pkg::ST_OUT];

    hbs_axis u_axis_x (
        .clk        (clk),
        .ctrl       (ctrl),
        .coord      (query_x),
        .origin     (x_origin_reg),
        .scale      (x_scale_reg),
        .last_index (last_col_use),
        .index      (col_idx),
        .frac       (col_frac)
    );

    hbs_axis u_axis_y (
        .clk        (clk),
        .ctrl       (ctrl),
        .coord      (query_y),
        .origin     (y_origin_reg),
        .scale      (y_scale_reg),
        .last_index (last_row_use),
        .index      (row_idx),
        .frac       (row_frac)
    );

    hbs_grid #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_grid (
        .clk         (clk),
        .ctrl        (ctrl),
        .load_column (load_column),
        .load_row    (load_row),
        .load_height (load_height),
        .col         (col_idx),
        .col_frac    (col_frac),
        .row         (row_idx),
        .row_frac    (row_frac),
        .ll          (h_ll),
        .lr          (h_lr),
        .ul          (h_ul),
        .ur          (h_ur)
    );

    hbs_blend #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_blend (
        .clk        (clk),
        .ctrl       (ctrl),
        .grid_valid (grid_valid_reg),
        .col_frac   (col_frac),
        .row_frac   (row_frac),
        .ll         (h_ll),
        .lr         (h_lr),
        .ul         (h_ul),
        .ur         (h_ur),
        .height_out (height_out),
        .found      (found)
    );

endmodule

`default_nettype wire

[rtl/hbs_checker.sv]
// Port-level checks of the height grid sampler and their bind.
`default_nettype none

`include "heightfield_bilinear_sample_top_defines.svh"

module hbs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] height_out,
    input logic               found
);

    `HBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(height_out) && $stable(found), "result changed or dropped while stalled")
    `HBS_ASSERT_SAME(a_empty_out_ready, clk, rst_n, !out_valid, in_ready, "input blocked with output stage empty")
    `HBS_ASSERT_SAME(a_not_found_zero, clk, rst_n, out_valid && !found, height_out == 32'sd0, "nonzero height without a valid grid")

endmodule

bind heightfield_bilinear_sample_top hbs_checker u_hbs_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the bilinear height grid sampler.
`timescale 1ns / 100ps

module tb_top;

    localparam int GRID_COLS = 256;
    localparam int SETTLE    = hbs_pkg::NUM_STAGES + 4;
    localparam int RANDOM_ITEMS = 650;

    typedef struct packed {
        logic signed [31:0] height;
        logic               found;
    } hb_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               op;
    logic [7:0]         load_column;
    logic [7:0]         load_row;
    logic signed [15:0] load_height;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] height_out;
    logic               found;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    logic               cfg_grid_valid;
    logic [31:0]        cfg_x_origin;
    logic [31:0]        cfg_y_origin;
    logic [31:0]        cfg_x_scale;
    logic [31:0]        cfg_y_scale;
    logic [7:0]         cfg_last_column;
    logic [7:0]         cfg_last_row;

    logic signed [15:0] grid_mem [0:GRID_COLS*GRID_COLS-1];
    bit                 grid_written [0:GRID_COLS*GRID_COLS-1];
    hb_result_t         pending_results [$];
    hb_result_t         due;

    int  mismatch_count;
    int  items_sent;
    bit  steady_flow;
    int  ready_hold;
    int  roll;

    heightfield_bilinear_sample_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .load_column (load_column),
        .load_row    (load_row),
        .load_height (load_height),
        .query_x     (query_x),
        .query_y     (query_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .height_out  (height_out),
        .found       (found),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Q16.16 grid position, clamped to [0, last]
    function automatic logic [63:0] map_axis(logic [31:0] q, logic [31:0] origin,
                                             logic [31:0] scale, logic [7:0] last);
        logic signed [63:0] d;
        logic [63:0]        du;
        logic [63:0]        p;
        logic [63:0]        lim;
        d = $signed({{32{q[31]}}, q}) - $signed({{32{origin[31]}}, origin});
        if (d <= 0)
            return 64'd0;
        du  = d;
        p   = (du * {32'd0, scale}) >> 16;
        lim = {40'd0, last, 16'd0};
        if (p > lim)
            p = lim;
        return p;
    endfunction

    function automatic hb_result_t predict_height(logic [31:0] qx, logic [31:0] qy);
        hb_result_t         res;
        logic [63:0]        cp;
        logic [63:0]        rp;
        int                 c0, c1, r0, r1;
        logic signed [63:0] fx, fy, ll, lrv, ul, ur, lo, hi, v;
        res.height = '0;
        res.found  = 1'b0;
        if (!cfg_grid_valid)
            return res;
        cp = map_axis(qx, cfg_x_origin, cfg_x_scale, cfg_last_column);
        rp = map_axis(qy, cfg_y_origin, cfg_y_scale, cfg_last_row);
        c0 = int'(cp[23:16]);
        r0 = int'(rp[23:16]);
        fx = {48'd0, cp[15:0]};
        fy = {48'd0, rp[15:0]};
        c1 = (fx != 0) ? c0 + 1 : c0;
        r1 = (fy != 0) ? r0 + 1 : r0;
        ll  = 64'(grid_mem[r0 * GRID_COLS + c0]);
        lrv = 64'(grid_mem[r0 * GRID_COLS + c1]);
        ul  = 64'(grid_mem[r1 * GRID_COLS + c0]);
        ur  = 64'(grid_mem[r1 * GRID_COLS + c1]);
        lo = ll * (64'sd65536 - fx) + lrv * fx;
        hi = ul * (64'sd65536 - fx) + ur * fx;
        v  = ((lo >>> 16) * (64'sd65536 - fy) + (hi >>> 16) * fy + 64'sd32768) >>> 16;
        if (v > hbs_pkg::SAT_MAX)
            v = hbs_pkg::SAT_MAX;
        else if (v < hbs_pkg::SAT_MIN)
            v = hbs_pkg::SAT_MIN;
        res.height = v[31:0];
        res.found  = 1'b1;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [15:0] pick_height();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 16'sh8000;
        if (r < 4)
            return 16'sh7FFF;
        if (r == 4)
            return 16'sh0000;
        return 16'($urandom);
    endfunction

    // coordinate that mostly lands inside the grid in use
    function automatic logic [31:0] pick_coord(logic [31:0] origin, logic [31:0] scale,
                                               logic [7:0] last);
        logic signed [63:0] pos;
        logic signed [63:0] x;
        int                 r;
        r = $urandom_range(0, 9);
        if (r < 2 || scale == 0)
            return $urandom;
        if (r < 4)
            pos = 64'($urandom_range(0, int'(last))) <<< 16;
        else if (r == 4)
            pos = -64'($urandom_range(1, 1 << 20));
        else if (r == 5)
            pos = 64'(int'(last) + $urandom_range(1, 8)) <<< 16;
        else
            pos = 64'($urandom_range(0, int'(last) << 16));
        x = $signed({{32{origin[31]}}, origin}) + (pos <<< 16) / $signed({32'd0, scale});
        return x[31:0];
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] col, input logic [7:0] row,
                             input logic signed [15:0] hgt, input logic [31:0] qx,
                             input logic [31:0] qy);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        load_column <= col;
        load_row    <= row;
        load_height <= hgt;
        query_x     <= qx;
        query_y     <= qy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (kind == hbs_pkg::OP_LOAD)
        begin
            grid_mem[{row, col}]     = hgt;
            grid_written[{row, col}] = 1'b1;
        end
        else
            pending_results.push_back(predict_height(qx, qy));
    endtask

    task automatic send_load(input logic [7:0] col, input logic [7:0] row,
                             input logic signed [15:0] hgt);
        send_item(hbs_pkg::OP_LOAD, col, row, hgt, $urandom, $urandom);
    endtask

    task automatic send_query(input logic [31:0] qx, input logic [31:0] qy);
        send_item(hbs_pkg::OP_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), qx, qy);
    endtask

    task automatic send_grid_query();
        send_query(pick_coord(cfg_x_origin, cfg_x_scale, cfg_last_column),
                   pick_coord(cfg_y_origin, cfg_y_scale, cfg_last_row));
    endtask

    // loads can still be in flight with nothing pending, so settle afterwards
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic put_reg(input hbs_pkg::reg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            hbs_pkg::REG_GRID_VALID:  cfg_grid_valid  = data[0];
            hbs_pkg::REG_X_ORIGIN:    cfg_x_origin    = data;
            hbs_pkg::REG_Y_ORIGIN:    cfg_y_origin    = data;
            hbs_pkg::REG_X_SCALE:     cfg_x_scale     = data;
            hbs_pkg::REG_Y_SCALE:     cfg_y_scale     = data;
            hbs_pkg::REG_LAST_COLUMN: cfg_last_column = data[7:0];
            hbs_pkg::REG_LAST_ROW:    cfg_last_row    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic gv, input logic [31:0] xo, input logic [31:0] yo,
                              input logic [31:0] xs, input logic [31:0] ys,
                              input logic [7:0] lc, input logic [7:0] lr);
        put_reg(hbs_pkg::REG_GRID_VALID, {31'd0, gv});
        put_reg(hbs_pkg::REG_X_ORIGIN, xo);
        put_reg(hbs_pkg::REG_Y_ORIGIN, yo);
        put_reg(hbs_pkg::REG_X_SCALE, xs);
        put_reg(hbs_pkg::REG_Y_SCALE, ys);
        put_reg(hbs_pkg::REG_LAST_COLUMN, {24'd0, lc});
        put_reg(hbs_pkg::REG_LAST_ROW, {24'd0, lr});
        cfg_valid <= 1'b0;
    endtask

    // every sample a query can touch must be written first
    task automatic fill_region();
        for (int r = 0; r <= int'(cfg_last_row); r++)
            for (int c = 0; c <= int'(cfg_last_column); c++)
                if (!grid_written[r * GRID_COLS + c])
                    send_load(c[7:0], r[7:0], pick_height());
    endtask

    task automatic test_invalid_grid();
        send_query(32'h0000_0000, 32'h0000_0000);
        send_load(8'd255, 8'd255, 16'sh8000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_load(8'd0, 8'd0, 16'sh7FFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_load(8'd170, 8'd85, 16'sh5555);
        send_query($urandom, $urandom);
        send_query(32'hFFFF_FFFF, 32'h0001_8000);
    endtask

    task automatic test_directed_blend();
        logic signed [15:0] pattern [16];
        pattern = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sd1,
                    16'sd1, 16'sd12345, -16'sd12345, 16'sh7FFF,
                    16'sh8000, 16'sd100, -16'sd200, 16'sd300,
                    16'sh7FFF, 16'sh8000, 16'sd7, -16'sd7};
        drain_pipeline();
        set_config(1'b1, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 8'd3, 8'd3);
        for (int i = 0; i < 16; i++)
            send_load(8'(i % 4), 8'(i / 4), pattern[i]);
        send_query(32'h0000_0000, 32'h0000_0000);
        send_query(32'h0003_0000, 32'h0003_0000);
        send_query(32'h0001_8000, 32'h0002_4000);
        send_query(32'h0000_0001, 32'h0002_FFFF);
        send_query(32'hFFFB_0000, 32'h000A_0000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h0002_8000, 32'h0000_8000);
    endtask

    task automatic test_register_extremes();
        drain_pipeline();
        set_config(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'd255, 8'd0);
        fill_region();
        send_query(32'h8000_0000, 32'h8000_0000);
        send_query(32'h8000_FFFF, 32'h7FFF_FFFF);
        repeat (12) send_grid_query();
        drain_pipeline();
        set_config(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 8'd0, 8'd255);
        fill_region();
        send_query(32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h8000_0000, 32'h8000_8000);
        repeat (12) send_grid_query();
        drain_pipeline();
        set_config(1'b1, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 8'd0, 8'd0);
        send_query(32'h0000_8000, 32'h0000_8000);
        repeat (6) send_grid_query();
    endtask

    task automatic test_random_phases();
        int          first;
        int          n;
        int          r;
        logic [31:0] xo, yo, xs, ys;
        logic [7:0]  lc, lr;
        logic        gv;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            drain_pipeline();
            gv = ($urandom_range(0, 9) != 0);
            for (int a = 0; a < 2; a++)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    xo = 32'($urandom_range(0, 128 << 16)) - 32'(64 << 16);
                else if (r < 8)
                    xo = $urandom;
                else if (r == 8)
                    xo = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                else
                    xo = 32'h0;
                r = $urandom_range(0, 9);
                if (r < 4)
                    xs = 32'h0001_0000;
                else if (r < 7)
                    xs = $urandom_range(1 << 13, 1 << 19);
                else if (r == 7)
                    xs = 32'h0;
                else if (r == 8)
                    xs = 32'hFFFF_FFFF;
                else
                    xs = $urandom;
                if (a == 0)
                begin
                    yo = xo;
                    ys = xs;
                end
            end
            if ($urandom_range(0, 4) == 0)
            begin
                lc = 8'($urandom_range(0, 255));
                lr = 8'($urandom_range(0, 3));
                if ($urandom_range(0, 1) != 0)
                    {lc, lr} = {lr, lc};
            end
            else
            begin
                lc = 8'($urandom_range(0, 15));
                lr = 8'($urandom_range(0, 15));
            end
            set_config(gv, xo, yo, xs, ys, lc, lr);
            steady_flow = ($urandom_range(0, 4) == 0);
            fill_region();
            n = $urandom_range(20, 80);
            repeat (n)
            begin
                r = $urandom_range(0, 19);
                if (r < 15)
                    send_grid_query();
                else if (r < 17)
                    send_query($urandom, $urandom);
                else
                    send_load(8'($urandom), 8'($urandom), pick_height());
            end
        end
        steady_flow = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (steady_flow)
            out_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                out_ready  <= 1'b1;
                ready_hold <= $urandom_range(0, 6);
            end
            else if (roll < 93)
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_hold <= $urandom_range(8, 40);
            end
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch($sformatf("unexpected result height=%0d found=%0b",
                                        height_out, found));
            else
            begin
                due = pending_results.pop_front();
                if (found !== due.found)
                    flag_mismatch($sformatf("found got %b want %b", found, due.found));
                if (height_out !== due.height)
                    flag_mismatch($sformatf("height_out got %0d want %0d",
                                            height_out, due.height));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = hbs_pkg::OP_LOAD;
        load_column     = '0;
        load_row        = '0;
        load_height     = '0;
        query_x         = '0;
        query_y         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = hbs_pkg::REG_GRID_VALID;
        cfg_data        = '0;
        cfg_grid_valid  = 1'b0;
        cfg_x_origin    = 32'h0;
        cfg_y_origin    = 32'h0;
        cfg_x_scale     = 32'h0001_0000;
        cfg_y_scale     = 32'h0001_0000;
        cfg_last_column = 8'd255;
        cfg_last_row    = 8'd255;
        mismatch_count  = 0;
        items_sent      = 0;
        steady_flow     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_invalid_grid();
        test_directed_blend();
        test_register_extremes();
        test_random_phases();
        drain_pipeline();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
